/* sv/vertex_project_to_screen_macros.svh */
// Assertion macros for the vertex projection block.
// Each check is sampled on the rising edge of aclk and is off while aresetn is low.
`ifndef VERTEX_PROJECT_TO_SCREEN_MACROS_SVH
`define VERTEX_PROJECT_TO_SCREEN_MACROS_SVH
`ifndef SYNTHESIS
`define VPTS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define VPTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VPTS_ASSERT_IMPL(label, ante, cons, msg)
`define VPTS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* sv/vpts_pkg.sv */
package vpts_pkg;

    // Field and datapath widths.
    localparam int OUT_WIDTH = 16;
    localparam int VTX_W     = 32;
    localparam int COEF_W    = 16;
    localparam int ROW_W     = 4 * COEF_W;
    localparam int PROD_W    = VTX_W + COEF_W;
    localparam int H_W       = PROD_W + 2;
    localparam int MAG_W     = H_W - 1;
    localparam int SIZE_W    = 15;
    localparam int OFF_W     = SIZE_W - 1;
    localparam int NUM_W     = MAG_W + SIZE_W;
    localparam int DEN_W     = MAG_W + 1;
    // Quotient bits kept: enough that a clamped quotient still saturates after the offset.
    localparam int QUO_W     = ((OUT_WIDTH > OFF_W + 1) ? OUT_WIDTH : OFF_W + 1) + 1;
    localparam int CFG_IDX_W = 3;

    // Queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // Register reset values.
    localparam logic [ROW_W-1:0] ROW0_RST = 64'd7416;
    localparam logic [ROW_W-1:0] ROW1_RST = 64'd648085504;
    localparam logic [ROW_W-1:0] ROW2_RST = 64'd18215952219352596480;
    localparam logic [ROW_W-1:0] ROW3_RST = 64'd17592186044416;
    localparam logic [12:0]      WIDTH_RST  = 13'd640;
    localparam logic [12:0]      HEIGHT_RST = 13'd480;
    localparam logic [14:0]      DEPTH_RST  = 15'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0   = 3'd0,
        CFG_ROW1   = 3'd1,
        CFG_ROW2   = 3'd2,
        CFG_ROW3   = 3'd3,
        CFG_WIDTH  = 3'd4,
        CFG_HEIGHT = 3'd5,
        CFG_DEPTH  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [3:0][ROW_W-1:0] row;
        logic [12:0]           frame_width;
        logic [12:0]           frame_height;
        logic [14:0]           depth_range;
    } vpts_cfg_t;

    typedef struct packed {
        logic signed [VTX_W-1:0] vert_x;
        logic signed [VTX_W-1:0] vert_y;
        logic signed [VTX_W-1:0] vert_z;
    } vtx_in_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] screen_x;
        logic signed [OUT_WIDTH-1:0] screen_y;
        logic signed [OUT_WIDTH-1:0] screen_depth;
        logic                        visible;
        logic                        w_zero;
    } vtx_out_t;

    // One classified vertex as queued for the back.
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic [MAG_W-1:0]      wmag;
        logic                  w_zero;
        logic                  visible;
    } vpts_cls_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } vpts_qstat_t;

endpackage

/* sv/vertex_project_to_screen.sv */
// Channel   Ports                        Word
// input     s_valid s_ready s_data       vertex x, y, z in signed Q16.16
// result    m_valid m_ready m_data       screen x, y, depth, visible, w_zero
// config    cfg_we cfg_idx cfg_wdata     matrix rows, frame size, depth scale
//
// One vertex is accepted per cycle unless the full queue holds up the front, and one result
// leaves per cycle while the receiver takes it. A result passes the input register, three
// front stages, one queue write, then 1 + (QUO_W + 1) + 1 back stages (QUO_W is 17 at the
// default output width); the restoring divider makes up most of them.
// Reset clears control state only; the register file returns to its reset values.
// A stalled result freezes the back; the front keeps taking vertices until the
// four-word queue and its own stages are full.
`include "vertex_project_to_screen_macros.svh"

module vertex_project_to_screen (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  vpts_pkg::vtx_in_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output vpts_pkg::vtx_out_t                m_data,
    input  logic                              cfg_we,
    input  logic [vpts_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [vpts_pkg::ROW_W-1:0]        cfg_wdata
);

    vpts_pkg::vpts_cfg_t   cfg;
    vpts_pkg::vpts_cls_t   q_wdata, q_rdata;
    vpts_pkg::vpts_qstat_t q_stat;
    logic                  q_push, q_pop;
    logic                  wz_word_clean;
    logic                  q_count_ok;

    vpts_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_wdata(cfg_wdata),
        .cfg      (cfg)
    );

    vpts_front u_front (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cfg    (cfg),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .q_full (q_stat.full),
        .q_push (q_push),
        .q_wdata(q_wdata)
    );

    vpts_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .stat   (q_stat)
    );

    vpts_back u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cfg    (cfg),
        .q_rdata(q_rdata),
        .q_empty(q_stat.empty),
        .q_pop  (q_pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // Terms used by the checks below.
    assign wz_word_clean = !m_data.visible && (m_data.screen_x == '0)
                           && (m_data.screen_y == '0) && (m_data.screen_depth == '0);
    assign q_count_ok    = (q_stat.count <= vpts_pkg::QCNT_W'(vpts_pkg::QDEPTH));

    // A zero-w result carries nothing but its flag.
`VPTS_ASSERT_IMPL(a_wzero_clean, m_valid && m_data.w_zero, wz_word_clean, "zero-w word has data")
    // The front only holds off input when the queue is full.
`VPTS_ASSERT_IMPL(a_ready_full, !s_ready, q_stat.full, "input stalled with room in queue")
    // The fill count never passes the queue depth.
`VPTS_ASSERT_IMPL(a_count_bound, 1'b1, q_count_ok, "queue count out of range")
    // A full queue stays full until the back pops a word.
`VPTS_ASSERT_NEXT(a_full_holds, q_stat.full && !q_pop, q_stat.full, "full queue lost a word")

endmodule

/* sv/vpts_cfg.sv */
module vpts_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [vpts_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [vpts_pkg::ROW_W-1:0]        cfg_wdata,
    output vpts_pkg::vpts_cfg_t               cfg
);

    vpts_pkg::vpts_cfg_t cfg_reg;

    // Register file: one write per cycle, indexes past the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row[0]       <= vpts_pkg::ROW0_RST;
            cfg_reg.row[1]       <= vpts_pkg::ROW1_RST;
            cfg_reg.row[2]       <= vpts_pkg::ROW2_RST;
            cfg_reg.row[3]       <= vpts_pkg::ROW3_RST;
            cfg_reg.frame_width  <= vpts_pkg::WIDTH_RST;
            cfg_reg.frame_height <= vpts_pkg::HEIGHT_RST;
            cfg_reg.depth_range  <= vpts_pkg::DEPTH_RST;
        end else if (cfg_we) begin
            unique case (vpts_pkg::cfg_idx_t'(cfg_idx))
                vpts_pkg::CFG_ROW0:   cfg_reg.row[0] <= cfg_wdata;
                vpts_pkg::CFG_ROW1:   cfg_reg.row[1] <= cfg_wdata;
                vpts_pkg::CFG_ROW2:   cfg_reg.row[2] <= cfg_wdata;
                vpts_pkg::CFG_ROW3:   cfg_reg.row[3] <= cfg_wdata;
                vpts_pkg::CFG_WIDTH:  cfg_reg.frame_width  <= cfg_wdata[12:0];
                vpts_pkg::CFG_HEIGHT: cfg_reg.frame_height <= cfg_wdata[12:0];
                vpts_pkg::CFG_DEPTH:  cfg_reg.depth_range  <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/vpts_front.sv */
module vpts_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  vpts_pkg::vpts_cfg_t  cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  vpts_pkg::vtx_in_t    s_data,
    input  logic                 q_full,
    output logic                 q_push,
    output vpts_pkg::vpts_cls_t  q_wdata
);

    localparam int PW = vpts_pkg::PROD_W;
    localparam int HW = vpts_pkg::H_W;
    localparam int MW = vpts_pkg::MAG_W;
    localparam int CW = vpts_pkg::COEF_W;

    logic                      fe;
    logic                      f1_valid_reg, f2_valid_reg, f3_valid_reg, f4_valid_reg;
    vpts_pkg::vtx_in_t         f1_data_reg;
    logic signed [vpts_pkg::VTX_W-1:0] comp [3];
    logic signed [PW-1:0]      prod_reg [4][3];
    logic signed [CW-1:0]      c3_reg [4];
    logic signed [HW-1:0]      h_reg [4];
    logic [MW-1:0]             mag [4];
    vpts_pkg::vpts_cls_t       cls_next, f4_data_reg;

    // The whole front moves unless its last stage holds a word the queue cannot take.
    assign fe      = !f4_valid_reg || !q_full;
    assign s_ready = fe;
    assign q_push  = f4_valid_reg && !q_full;
    assign q_wdata = f4_data_reg;

    assign comp[0] = f1_data_reg.vert_x;
    assign comp[1] = f1_data_reg.vert_y;
    assign comp[2] = f1_data_reg.vert_z;

    // Valid chain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            f4_valid_reg <= 1'b0;
        end else if (fe) begin
            f1_valid_reg <= s_valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            f4_valid_reg <= f3_valid_reg;
        end
    end

    // Input register, then the twelve coefficient products.
    always_ff @(posedge aclk) begin
        if (fe) begin
            f1_data_reg <= s_data;
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[r][c] <= PW'(comp[c]) * PW'($signed(cfg.row[r][CW*c +: CW]));
                end
                c3_reg[r] <= $signed(cfg.row[r][CW*3 +: CW]);
            end
        end
    end

    // Row sums; the constant column is scaled up to the product format.
    always_ff @(posedge aclk) begin
        if (fe) begin
            for (int r = 0; r < 4; r++) begin
                h_reg[r] <= HW'(prod_reg[r][0]) + HW'(prod_reg[r][1]) + HW'(prod_reg[r][2])
                          + (HW'(c3_reg[r]) <<< 16);
            end
        end
    end

    // Classification: magnitudes, quotient signs, zero w and the clip test.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            mag[r] = h_reg[r][HW-1] ? MW'(-h_reg[r]) : MW'(h_reg[r]);
        end
        for (int i = 0; i < 3; i++) begin
            cls_next.mag[i] = mag[i];
            cls_next.neg[i] = h_reg[i][HW-1] ^ h_reg[3][HW-1];
        end
        cls_next.wmag    = mag[3];
        cls_next.w_zero  = (h_reg[3] == '0);
        cls_next.visible = (mag[0] <= mag[3]) && (mag[1] <= mag[3]) && (mag[2] <= mag[3]);
    end

    always_ff @(posedge aclk) begin
        if (fe) begin
            f4_data_reg <= cls_next;
        end
    end

endmodule

/* sv/vpts_queue.sv */
module vpts_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  vpts_pkg::vpts_cls_t  wdata,
    input  logic                 pop,
    output vpts_pkg::vpts_cls_t  rdata,
    output vpts_pkg::vpts_qstat_t stat
);

    localparam int PW = vpts_pkg::QPTR_W;
    localparam int CW = vpts_pkg::QCNT_W;

    vpts_pkg::vpts_cls_t mem_reg [vpts_pkg::QDEPTH];
    logic [PW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]       count_reg;

    // Pointers and fill count; the front never pushes into a full queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CW'(vpts_pkg::QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

endmodule

/* sv/vpts_div.sv */
module vpts_div #(
    parameter int NUM_W = vpts_pkg::NUM_W,
    parameter int DEN_W = vpts_pkg::DEN_W,
    parameter int QB    = vpts_pkg::QUO_W
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QB-1:0]    quo
);

    // First stage tests for overflow, each later one settles one quotient bit.
    localparam int RW  = (DEN_W + QB > NUM_W) ? DEN_W + QB : NUM_W;
    localparam int LAT = QB + 1;

    logic [RW-1:0]    rem_reg [LAT-1];
    logic [DEN_W-1:0] den_reg [LAT-1];
    logic [QB-1:0]    q_reg [LAT];
    logic             ovf_reg [LAT];

    for (genvar i = 0; i < LAT; i++) begin : g_stage
        logic [RW-1:0]    rem_in, step;
        logic [DEN_W-1:0] den_in;
        logic [QB-1:0]    q_in;
        logic             ovf_in, ge;

        if (i == 0) begin : g_first
            assign rem_in = RW'(num);
            assign den_in = den;
            assign q_in   = '0;
            assign ovf_in = 1'b0;
        end else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign ovf_in = ovf_reg[i-1];
        end

        assign step = RW'(den_in) << (QB - i);
        assign ge   = (rem_in >= step);

        if (i == 0) begin : g_ovf
            always_ff @(posedge aclk) begin
                if (en) begin
                    ovf_reg[i] <= ge;
                    q_reg[i]   <= q_in;
                    rem_reg[i] <= rem_in;
                    den_reg[i] <= den_in;
                end
            end
        end else begin : g_bit
            logic sub;
            assign sub = !ovf_in && ge;
            always_ff @(posedge aclk) begin
                if (en) begin
                    ovf_reg[i] <= ovf_in;
                    q_reg[i]   <= sub ? (q_in | (QB'(1) << (QB - i))) : q_in;
                end
            end
            if (i < LAT - 1) begin : g_carry
                always_ff @(posedge aclk) begin
                    if (en) begin
                        rem_reg[i] <= sub ? (rem_in - step) : rem_in;
                        den_reg[i] <= den_in;
                    end
                end
            end
        end
    end

    // An oversized quotient is clamped; the caller saturates it.
    assign quo = ovf_reg[LAT-1] ? '1 : q_reg[LAT-1];

endmodule

/* sv/vpts_back.sv */
module vpts_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  vpts_pkg::vpts_cfg_t   cfg,
    input  vpts_pkg::vpts_cls_t   q_rdata,
    input  logic                  q_empty,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output vpts_pkg::vtx_out_t    m_data
);

    localparam int QB  = vpts_pkg::QUO_W;
    localparam int LAT = QB + 1;
    localparam int NW  = vpts_pkg::NUM_W;
    localparam int OW  = vpts_pkg::OUT_WIDTH;
    localparam int FW  = vpts_pkg::OFF_W;
    localparam int SW  = QB + 2;

    typedef struct packed {
        logic [2:0]         neg;
        logic [2:0][FW-1:0] off;
        logic               visible;
        logic               w_zero;
    } side_t;

    logic                       be;
    logic [vpts_pkg::SIZE_W-1:0] size [3];
    logic                       b0_valid_reg;
    logic [NW-1:0]              num_reg [3];
    logic [vpts_pkg::DEN_W-1:0] den_reg;
    side_t                      b0_side_reg;
    logic                       vld_reg [LAT];
    side_t                      side_reg [LAT];
    logic [QB-1:0]              quo [3];
    logic                       out_valid_reg;
    vpts_pkg::vtx_out_t         out_reg, out_next;
    logic signed [OW-1:0]       coord [3];

    // The back moves as one unless its output word is stalled.
    assign be    = !out_valid_reg || m_ready;
    assign q_pop = !q_empty && be;

    assign size[0] = vpts_pkg::SIZE_W'(cfg.frame_width);
    assign size[1] = vpts_pkg::SIZE_W'(cfg.frame_height);
    assign size[2] = cfg.depth_range;

    // Numerators |h| * size, divisor 2|w| and the half-size offsets.
    always_ff @(posedge aclk) begin
        if (be) begin
            for (int i = 0; i < 3; i++) begin
                num_reg[i]         <= NW'(q_rdata.mag[i]) * NW'(size[i]);
                b0_side_reg.off[i] <= size[i][vpts_pkg::SIZE_W-1:1];
            end
            den_reg             <= {q_rdata.wmag, 1'b0};
            b0_side_reg.neg     <= q_rdata.neg;
            b0_side_reg.visible <= q_rdata.visible;
            b0_side_reg.w_zero  <= q_rdata.w_zero;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        vpts_div #(
            .NUM_W(NW),
            .DEN_W(vpts_pkg::DEN_W),
            .QB   (QB)
        ) u_div (
            .aclk(aclk),
            .en  (be),
            .num (num_reg[i]),
            .den (den_reg),
            .quo (quo[i])
        );
    end

    // Sideband and valid bits follow the divider latency.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < LAT; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else if (be) begin
            b0_valid_reg  <= q_pop;
            vld_reg[0]    <= b0_valid_reg;
            for (int s = 1; s < LAT; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (be) begin
            side_reg[0] <= b0_side_reg;
            for (int s = 1; s < LAT; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
            out_reg <= out_next;
        end
    end

    // Offset plus signed quotient, saturated to the output range; a zero-w word gives zeros.
    always_comb begin
        logic signed [SW-1:0] v;
        logic                 fits;
        for (int i = 0; i < 3; i++) begin
            v = side_reg[LAT-1].neg[i] ? ($signed(SW'(side_reg[LAT-1].off[i])) - $signed(SW'(quo[i])))
                                       : ($signed(SW'(side_reg[LAT-1].off[i])) + $signed(SW'(quo[i])));
            fits = (v[SW-1:OW-1] == '0) || (v[SW-1:OW-1] == '1);
            if (side_reg[LAT-1].w_zero) begin
                coord[i] = '0;
            end else if (fits) begin
                coord[i] = v[OW-1:0];
            end else begin
                coord[i] = v[SW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
            end
        end
        out_next.screen_x     = coord[0];
        out_next.screen_y     = coord[1];
        out_next.screen_depth = coord[2];
        out_next.visible      = side_reg[LAT-1].visible && !side_reg[LAT-1].w_zero;
        out_next.w_zero       = side_reg[LAT-1].w_zero;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

/* dv/tb_vertex_project_to_screen.sv */
module tb_vertex_project_to_screen;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 40;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    vpts_pkg::vtx_in_t s_data;
    logic m_valid;
    logic m_ready;
    vpts_pkg::vtx_out_t m_data;
    logic cfg_we;
    logic [vpts_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [vpts_pkg::ROW_W-1:0] cfg_wdata;

    // Local copy of the register file used by the predictor.
    logic [vpts_pkg::ROW_W-1:0] mat_row [4];
    logic [12:0] fb_width;
    logic [12:0] fb_height;
    logic [14:0] z_range;

    vpts_pkg::vtx_out_t screen_expected [$];
    int error_count;
    int vertices_sent;
    int results_seen;
    int idle_cycles;
    bit src_idle_en;
    bit sink_idle_en;
    bit sink_hold;

    vertex_project_to_screen dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Signed 16-bit matrix entry c of a row, widened.
    function automatic longint entry_of(logic [vpts_pkg::ROW_W-1:0] row, int c);
        logic signed [15:0] e;
        e = row[16*c +: 16];
        return longint'(e);
    endfunction

    function automatic longint homog_dot(logic [vpts_pkg::ROW_W-1:0] row, longint x,
                                         longint y, longint z);
        return x * entry_of(row, 0) + y * entry_of(row, 1) + z * entry_of(row, 2)
             + entry_of(row, 3) * 65536;
    endfunction

    // Viewport mapping: half size plus the truncated scaled ratio, saturated.
    function automatic logic signed [vpts_pkg::OUT_WIDTH-1:0] viewport_map(longint h,
                                                                           longint w,
                                                                           longint size);
        longint v;
        longint num;
        longint den;
        longint q;
        num = h * size;
        den = 2 * w;
        q = num / den;
        v = (size >>> 1) + q;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[vpts_pkg::OUT_WIDTH-1:0];
    endfunction

    function automatic vpts_pkg::vtx_out_t project_vertex(vpts_pkg::vtx_in_t vin);
        vpts_pkg::vtx_out_t r;
        longint x;
        longint y;
        longint z;
        longint h0;
        longint h1;
        longint h2;
        longint h3;
        longint aw;
        x = longint'(vin.vert_x);
        y = longint'(vin.vert_y);
        z = longint'(vin.vert_z);
        h0 = homog_dot(mat_row[0], x, y, z);
        h1 = homog_dot(mat_row[1], x, y, z);
        h2 = homog_dot(mat_row[2], x, y, z);
        h3 = homog_dot(mat_row[3], x, y, z);
        r = '0;
        if (h3 == 0) begin
            r.w_zero = 1'b1;
            return r;
        end
        aw = (h3 < 0) ? -h3 : h3;
        r.screen_x = viewport_map(h0, h3, longint'(fb_width));
        r.screen_y = viewport_map(h1, h3, longint'(fb_height));
        r.screen_depth = viewport_map(h2, h3, longint'(z_range));
        r.visible = ((h0 < 0 ? -h0 : h0) <= aw) && ((h1 < 0 ? -h1 : h1) <= aw)
                 && ((h2 < 0 ? -h2 : h2) <= aw);
        return r;
    endfunction

    // One register write; the enable is dropped again before the next write can start.
    task automatic write_reg(vpts_pkg::cfg_idx_t idx, logic [vpts_pkg::ROW_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            vpts_pkg::CFG_ROW0: mat_row[0] = value;
            vpts_pkg::CFG_ROW1: mat_row[1] = value;
            vpts_pkg::CFG_ROW2: mat_row[2] = value;
            vpts_pkg::CFG_ROW3: mat_row[3] = value;
            vpts_pkg::CFG_WIDTH: fb_width = value[12:0];
            vpts_pkg::CFG_HEIGHT: fb_height = value[12:0];
            vpts_pkg::CFG_DEPTH: z_range = value[14:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Send one vertex word, with an optional idle burst before it. Valid stays high
    // after acceptance until the next word, an idle burst or a drain replaces it.
    task automatic send_vertex(vpts_pkg::vtx_in_t vin);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= vin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        screen_expected.insert(screen_expected.size(), project_vertex(vin));
        vertices_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (screen_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic vpts_pkg::vtx_in_t random_vertex();
        vpts_pkg::vtx_in_t v;
        case ($urandom_range(0, 3))
            0: begin
                v.vert_x = $urandom;
                v.vert_y = $urandom;
                v.vert_z = $urandom;
            end
            default: begin
                // Mostly coordinates of modest size so that many land on screen.
                v.vert_x = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
                v.vert_y = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
                v.vert_z = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            end
        endcase
        return v;
    endfunction

    function automatic logic [vpts_pkg::ROW_W-1:0] random_row();
        logic [vpts_pkg::ROW_W-1:0] r;
        r = {$urandom, $urandom};
        // Often keep entries small so outputs do not all saturate.
        if ($urandom_range(0, 1)) begin
            for (int c = 0; c < 4; c++) begin
                r[16*c +: 16] = 16'($signed($urandom_range(0, 16'h2000)) - 32'sh1000);
            end
        end
        return r;
    endfunction

    // Extremes of the vertex fields, zero w, and odd sizes.
    task automatic test_directed();
        vpts_pkg::vtx_in_t v;
        send_vertex('{32'sh0, 32'sh0, 32'sh0});
        send_vertex('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
        send_vertex('{-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000});
        send_vertex('{32'sh0001_0000, -32'sh0001_0000, 32'sh0002_0000});
        send_vertex('{32'sh0000_8000, 32'sh0000_8000, -32'sh0005_0000});
        send_vertex('{-32'sh1, 32'sh1, 32'sh7FFF_FFFF});
        drain_results();
        // Row 3 zero gives w zero for every vertex.
        write_reg(vpts_pkg::CFG_ROW3, 64'h0);
        send_vertex('{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000});
        send_vertex('{32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh0});
        drain_results();
        // Identity matrix with w taken from z, odd and smallest sizes.
        write_reg(vpts_pkg::CFG_ROW0, 64'h0000_0000_0000_1000);
        write_reg(vpts_pkg::CFG_ROW1, 64'h0000_0000_1000_0000);
        write_reg(vpts_pkg::CFG_ROW2, 64'h0000_1000_0000_0000);
        write_reg(vpts_pkg::CFG_ROW3, 64'h0000_1000_0000_0000);
        write_reg(vpts_pkg::CFG_WIDTH, 64'd1);
        write_reg(vpts_pkg::CFG_HEIGHT, 64'd4095);
        write_reg(vpts_pkg::CFG_DEPTH, 64'd32767);
        send_vertex('{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000});
        send_vertex('{-32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000});
        send_vertex('{32'sh0000_8000, -32'sh0000_8000, -32'sh0001_0000});
        send_vertex('{32'sh0001_0000, 32'sh0001_0000, 32'sh0});
        send_vertex('{32'sh7FFF_FFFF, 32'sh0, 32'sh1});
        drain_results();
        write_reg(vpts_pkg::CFG_WIDTH, 64'd4096);
        write_reg(vpts_pkg::CFG_HEIGHT, 64'd1);
        write_reg(vpts_pkg::CFG_DEPTH, 64'd1);
        write_reg(vpts_pkg::CFG_ROW0, 64'h8000_8000_8000_8000);
        write_reg(vpts_pkg::CFG_ROW1, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(vpts_pkg::CFG_ROW2, 64'hFFFF_FFFF_FFFF_FFFF);
        v = '{32'sh0003_0000, -32'sh0001_0000, 32'sh0002_0000};
        send_vertex(v);
        send_vertex('{-32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh8000_0000});
        send_vertex('{32'sh0, 32'sh0, 32'sh0001_0000});
        drain_results();
    endtask

    // Random vertices over several register settings.
    task automatic test_random(int phases, int per_phase);
        for (int p = 0; p < phases; p++) begin
            write_reg(vpts_pkg::CFG_ROW0, random_row());
            write_reg(vpts_pkg::CFG_ROW1, random_row());
            write_reg(vpts_pkg::CFG_ROW2, random_row());
            write_reg(vpts_pkg::CFG_ROW3, random_row());
            write_reg(vpts_pkg::CFG_WIDTH, 64'($urandom_range(1, 4096)));
            write_reg(vpts_pkg::CFG_HEIGHT, 64'($urandom_range(1, 4096)));
            write_reg(vpts_pkg::CFG_DEPTH, 64'($urandom_range(1, 32767)));
            for (int i = 0; i < per_phase; i++) send_vertex(random_vertex());
            drain_results();
        end
    endtask

    // The receiver holds off long while vertices keep coming back to back, so the
    // block fills and stalls its input; then the sender pauses until all results are back.
    task automatic test_backpressure();
        src_idle_en = 1'b0;
        sink_hold = 1'b1;
        fork
            begin
                repeat (60) @(posedge aclk);
                sink_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 40; i++) send_vertex(random_vertex());
            end
        join
        drain_results();
        src_idle_en = 1'b1;
    endtask

    task automatic test_streaming();
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        for (int i = 0; i < 150; i++) send_vertex(random_vertex());
        drain_results();
    endtask

    // Result receiver with random idle bursts.
    always @(posedge aclk) begin
        if (!aresetn || sink_hold) begin
            m_ready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 9) - 1) @(posedge aclk);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each result word with the oldest expectation.
    always @(posedge aclk) begin
        vpts_pkg::vtx_out_t exp_word;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (screen_expected.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, m_data);
                error_count++;
            end else begin
                exp_word = screen_expected[0];
                screen_expected.delete(0);
                if (m_data !== exp_word) begin
                    $display("%0t: mismatch expected x=%0d y=%0d d=%0d vis=%b wz=%b",
                             $time, exp_word.screen_x, exp_word.screen_y,
                             exp_word.screen_depth, exp_word.visible, exp_word.w_zero);
                    $display("%0t:          actual   x=%0d y=%0d d=%0d vis=%b wz=%b",
                             $time, m_data.screen_x, m_data.screen_y,
                             m_data.screen_depth, m_data.visible, m_data.w_zero);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired at %0t", $time);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_wdata = '0;
        m_ready = 1'b0;
        error_count = 0;
        vertices_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        sink_hold = 1'b0;
        mat_row[0] = vpts_pkg::ROW0_RST;
        mat_row[1] = vpts_pkg::ROW1_RST;
        mat_row[2] = vpts_pkg::ROW2_RST;
        mat_row[3] = vpts_pkg::ROW3_RST;
        fb_width = vpts_pkg::WIDTH_RST;
        fb_height = vpts_pkg::HEIGHT_RST;
        z_range = vpts_pkg::DEPTH_RST;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(6, 100);
        test_backpressure();
        test_streaming();

        $display("Sent %0d vertices, checked %0d results, %0d mismatches,",
                 vertices_sent, results_seen, error_count);
        $display("over reset, directed, random, stalled and streaming settings.");
        if (error_count == 0 && screen_expected.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
